// File: hdl/mvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants of the 4x4 matrix vector transform
// Widths of the Q16.16 datapath, the packed matrix and lane layouts, and the
// configuration register map.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int DATA_W        = 32;              // one Q16.16 entry
	localparam int DIM           = 4;               // matrix and vector size
	localparam int PROD_W        = 2 * DATA_W;      // one full product
	localparam int PAIR_W        = PROD_W + 1;      // sum of two products
	localparam int ACC_W         = PROD_W + 2;      // sum of four products
	localparam int NUM_PROD      = DIM * DIM;
	localparam int NUM_PAIR      = NUM_PROD / 2;
	localparam int CFG_W         = 2 * DATA_W;      // two entries per register
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = $clog2(NUM_REGS);
	localparam int FRAC_BITS_DEF = 16;
	localparam int ONE_Q         = 1 << FRAC_BITS_DEF;

	// func codes
	localparam logic FUNC_DIRECT = 1'b0;
	localparam logic FUNC_TRANSP = 1'b1;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic [DATA_W-1:0]                entry_t;
	typedef entry_t [DIM-1:0]                 vec4_t;
	typedef vec4_t  [DIM-1:0]                 mat4_t;    // [row][col]
	typedef logic [NUM_PROD-1:0][PROD_W-1:0]  prod_lanes_t;
	typedef logic [DIM-1:0][ACC_W-1:0]        acc_lanes_t;

endpackage

// File: hdl/mvt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_mul: product stage
// Picks each matrix entry (direct or transposed) and forms all sixteen
// signed 32x32 products in parallel, registered at stage 1.
// ----------------------------------------------------------------------------
module mvt_mul
	import mvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mat4_t       mat,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  vec4_t       vec,
	output logic        out_valid,
	input  logic        out_stall,
	output prod_lanes_t prod
);

	logic        valid_s1;
	prod_lanes_t prod_s1;
	prod_lanes_t prod_d;

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				prod_d[i*DIM+j] = PROD_W'($signed((func == FUNC_TRANSP) ? mat[j][i] : mat[i][j])
					* $signed(vec[j]));
			end
		end
	end

	assign in_stall = valid_s1 & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold products while the next stage stalls
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			prod_s1 <= prod_d;
		end
	end

	assign out_valid = valid_s1;
	assign prod      = prod_s1;

endmodule

// File: hdl/mvt_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_add: adder tree
// Reduces the four products of each output component in two registered
// levels: pairs at stage 2, the full sum at stage 3.
// ----------------------------------------------------------------------------
module mvt_add
	import mvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  prod_lanes_t prod,
	output logic        out_valid,
	input  logic        out_stall,
	output acc_lanes_t  acc
);

	logic                             valid_s2;
	logic                             valid_s3;
	logic [NUM_PAIR-1:0][PAIR_W-1:0]  pair_s2;
	acc_lanes_t                       acc_s3;
	logic [NUM_PAIR-1:0][PAIR_W-1:0]  pair_d;
	acc_lanes_t                       acc_d;
	logic                             stall_s3;

	always_comb begin
		for (int k = 0; k < NUM_PAIR; k++) begin
			pair_d[k] = {prod[2*k][PROD_W-1], prod[2*k]}
				+ {prod[2*k+1][PROD_W-1], prod[2*k+1]};
		end
		for (int k = 0; k < DIM; k++) begin
			acc_d[k] = {pair_s2[2*k][PAIR_W-1], pair_s2[2*k]}
				+ {pair_s2[2*k+1][PAIR_W-1], pair_s2[2*k+1]};
		end
	end

	assign stall_s3 = valid_s3 & out_stall;
	assign in_stall = valid_s2 & stall_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s2 <= in_valid;
			end
			if (!stall_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pair_s2 <= pair_d;
		end
		if (valid_s2 && !stall_s3) begin
			acc_s3 <= acc_d;
		end
	end

	assign out_valid = valid_s3;
	assign acc       = acc_s3;

endmodule

// File: hdl/mvt_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_sat: scale and clip stage
// Shifts each sum right by the fraction width, clips it to 32 bits and
// registers the result beat with the saturation flag at stage 4.
// ----------------------------------------------------------------------------
module mvt_sat
	import mvt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  acc_lanes_t acc,
	output logic       out_valid,
	input  logic       out_stall,
	output vec4_t      res,
	output logic       sat
);

	logic                          valid_s4;
	vec4_t                         res_s4;
	logic                          sat_s4;
	vec4_t                         res_d;
	logic [DIM-1:0]                clip;
	logic signed [ACC_W-1:0]       shifted;

	always_comb begin
		shifted = '0;
		for (int k = 0; k < DIM; k++) begin
			shifted = $signed(acc[k]) >>> FRAC_BITS;
			// in range when all bits from the 32-bit sign bit upward agree
			clip[k] = !((&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]));
			if (!clip[k]) begin
				res_d[k] = shifted[DATA_W-1:0];
			end else if (shifted[ACC_W-1]) begin
				res_d[k] = SAT_MIN;
			end else begin
				res_d[k] = SAT_MAX;
			end
		end
	end

	assign in_stall = valid_s4 & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (!in_stall) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			res_s4 <= res_d;
			sat_s4 <= |clip;
		end
	end

	assign out_valid = valid_s4;
	assign res       = res_s4;
	assign sat       = sat_s4;

endmodule

// File: hdl/matrix4_vector_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_vector_transform: 4x4 matrix times vector, signed Q16.16
// Transforms one vector per beat by the configured matrix or its transpose.
// ----------------------------------------------------------------------------
// The block accepts one vector beat every clock cycle while in_stall is low
// and returns one result beat per vector after it passes stages 1 to 4 in
// order. Rate is set by the sixteen parallel 32x32 multipliers at stage 1;
// stages 2 and 3 form the adder tree and stage 4 scales and clips. Each
// stage holds its own valid bit, so empty stages fill up while the output is
// stalled and the input stalls only once every stage holds a beat. The matrix
// sits in eight 64-bit registers (row R, columns 0/1 at index 2R, columns 2/3
// at index 2R+1, lower column in the low half) and resets to identity.
// Write them only while no beat is in flight. Each output component is the
// exact four-term sum shifted right by FRAC_BITS (toward minus infinity) and
// clipped to signed 32 bits; saturated flags any clipped component.
// ----------------------------------------------------------------------------
module matrix4_vector_transform
	import mvt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    func,
	input  logic signed [DATA_W-1:0] vec_x,
	input  logic signed [DATA_W-1:0] vec_y,
	input  logic signed [DATA_W-1:0] vec_z,
	input  logic signed [DATA_W-1:0] vec_w,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic signed [DATA_W-1:0] out_w,
	output logic                    saturated
);

	mat4_t       mat_q;
	vec4_t       vec;
	prod_lanes_t prod;
	acc_lanes_t  acc;
	vec4_t       res;
	logic        mul_valid;
	logic        mul_stall;
	logic        add_valid;
	logic        add_stall;
	logic [1:0]  cfg_row;
	logic        cfg_hi;

	// register index: upper bits pick the row, lowest bit the column pair
	assign cfg_row = cfg_index[CFG_IDX_W-1:1];
	assign cfg_hi  = cfg_index[0];

	// Hold the matrix; reset to identity, overwrite two entries per write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					mat_q[i][j] <= (i == j) ? DATA_W'(ONE_Q) : '0;
				end
			end
		end else if (cfg_wr_en) begin
			mat_q[cfg_row][{cfg_hi, 1'b0}] <= cfg_data[DATA_W-1:0];
			mat_q[cfg_row][{cfg_hi, 1'b1}] <= cfg_data[CFG_W-1:DATA_W];
		end
	end

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;
	assign vec[3] = vec_w;

	// Stage 1: select entries and multiply.
	mvt_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat       (mat_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.vec       (vec),
		.out_valid (mul_valid),
		.out_stall (mul_stall),
		.prod      (prod)
	);

	// Stages 2 and 3: reduce four products per component.
	mvt_add u_add (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_stall  (mul_stall),
		.prod      (prod),
		.out_valid (add_valid),
		.out_stall (add_stall),
		.acc       (acc)
	);

	// Stage 4: scale, clip and present the result beat.
	mvt_sat #(
		.FRAC_BITS (FRAC_BITS)
	) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (add_valid),
		.in_stall  (add_stall),
		.acc       (acc),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.sat       (saturated)
	);

	assign out_x = res[0];
	assign out_y = res[1];
	assign out_z = res[2];
	assign out_w = res[3];

endmodule
